>>> rtl/core/aes128_block_cipher_top_assert.svh
// assertion macros for the cipher rtl
`ifndef AES128_BLOCK_CIPHER_TOP_ASSERT_SVH
`define AES128_BLOCK_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define AES128_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aes128 assertion failed");

// next-cycle implication
`define AES128_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aes128 assertion failed");

`endif

>>> rtl/core/aes128_pkg.sv
// shared types, tables and round functions of the aes-128 pipeline
package aes128_pkg;

	localparam int NUM_RND = 10;
	localparam logic [3:0] LAST_RND = 4'd10;
	localparam logic [7:0] POLY = 8'h1b;

	// forward s-box, entry 0 in the top byte
	localparam logic [2047:0] SBOX_TBL = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	// inverse s-box, entry 0 in the top byte
	localparam logic [2047:0] INV_SBOX_TBL = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
	};

	typedef struct packed {
		logic         vld;
		logic         op;
		logic [127:0] key;
		logic [127:0] data;
		logic [127:0] kx;
	} kstg_t;

	typedef struct packed {
		logic         vld;
		logic         op;
		logic [127:0] s;
		logic [127:0] k;
	} pipe_t;

	function automatic logic [7:0] sb(input logic [7:0] x);
		logic [10:0] i;
		i = {~x, 3'b000};
		return SBOX_TBL[i +: 8];
	endfunction

	function automatic logic [7:0] isb(input logic [7:0] x);
		logic [10:0] i;
		i = {~x, 3'b000};
		return INV_SBOX_TBL[i +: 8];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd1: r = 8'h01;
			4'd2: r = 8'h02;
			4'd3: r = 8'h04;
			4'd4: r = 8'h08;
			4'd5: r = 8'h10;
			4'd6: r = 8'h20;
			4'd7: r = 8'h40;
			4'd8: r = 8'h80;
			4'd9: r = 8'h1b;
			4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
	endfunction

	function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t, n0, n1, n2, n3;
		t  = sbox_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// undo one key expansion step
	function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t, p0, p1, p2, p3;
		p3 = k[31:0] ^ k[63:32];
		p2 = k[63:32] ^ k[95:64];
		p1 = k[95:64] ^ k[127:96];
		t  = sbox_word({p3[23:0], p3[31:24]}) ^ {rc, 24'h0};
		p0 = k[127:96] ^ t;
		return {p0, p1, p2, p3};
	endfunction

	function automatic logic [127:0] sbox_state(input logic [127:0] s);
		logic [127:0] o;
		for (int n = 0; n < 16; n++) o[127-8*n -: 8] = sb(s[127-8*n -: 8]);
		return o;
	endfunction

	function automatic logic [127:0] isbox_state(input logic [127:0] s);
		logic [127:0] o;
		for (int n = 0; n < 16; n++) o[127-8*n -: 8] = isb(s[127-8*n -: 8]);
		return o;
	endfunction

	// byte r + 4c is row r, column c
	function automatic logic [127:0] rotate_rows(input logic [127:0] s);
		logic [127:0] o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
		return o;
	endfunction

	function automatic logic [127:0] unrotate_rows(input logic [127:0] s);
		logic [127:0] o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
		return o;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			o[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			o[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			o[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return o;
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] x);
		return xt(xt(xt(x))) ^ x;
	endfunction

	function automatic logic [7:0] mulb(input logic [7:0] x);
		return xt(xt(xt(x))) ^ xt(x) ^ x;
	endfunction

	function automatic logic [7:0] muld(input logic [7:0] x);
		return xt(xt(xt(x))) ^ xt(xt(x)) ^ x;
	endfunction

	function automatic logic [7:0] mule(input logic [7:0] x);
		return xt(xt(xt(x))) ^ xt(xt(x)) ^ xt(x);
	endfunction

	function automatic logic [127:0] unmix_cols(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			o[127-32*c -: 8] = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
			o[119-32*c -: 8] = mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3);
			o[111-32*c -: 8] = muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3);
			o[103-32*c -: 8] = mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3);
		end
		return o;
	endfunction

endpackage

>>> rtl/core/aes128_in_if.sv
// request channel carrying operation, key and block
interface aes128_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic [63:0] data_in_hi;
	logic [63:0] data_in_lo;

	modport source (output valid, operation, key_hi, key_lo, data_in_hi, data_in_lo,
		input ready);
	modport sink (input valid, operation, key_hi, key_lo, data_in_hi, data_in_lo,
		output ready);
endinterface

>>> rtl/core/aes128_out_if.sv
// result channel carrying the processed block
interface aes128_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_out_hi;
	logic [63:0] data_out_lo;

	modport source (output valid, data_out_hi, data_out_lo, input ready);
	modport sink (input valid, data_out_hi, data_out_lo, output ready);
endinterface

>>> rtl/core/aes128_round.sv
// one registered cipher round, encrypt or decrypt, with its round key step
module aes128_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [3:0]          rnd,
	input  aes128_pkg::pipe_t   d,
	output aes128_pkg::pipe_t   q
);

	logic [127:0] k_enc, k_dec, t_enc, t_dec, s_nxt, k_nxt;
	logic         last;

	always_comb begin
		last  = (rnd == aes128_pkg::LAST_RND);
		k_enc = aes128_pkg::key_fwd(d.k, aes128_pkg::rcon(rnd));
		// decrypt walks the schedule backward from the last round key
		k_dec = aes128_pkg::key_bwd(d.k, aes128_pkg::rcon(4'd11 - rnd));
		t_enc = aes128_pkg::rotate_rows(aes128_pkg::sbox_state(d.s));
		if (!last) t_enc = aes128_pkg::mix_cols(t_enc);
		t_dec = aes128_pkg::isbox_state(aes128_pkg::unrotate_rows(d.s)) ^ k_dec;
		if (!last) t_dec = aes128_pkg::unmix_cols(t_dec);
		s_nxt = d.op ? t_dec : (t_enc ^ k_enc);
		k_nxt = d.op ? k_dec : k_enc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.vld <= d.vld;
			q.op  <= d.op;
			q.s   <= s_nxt;
			q.k   <= k_nxt;
		end
	end

endmodule

>>> rtl/core/aes128_block_cipher_top.sv
// AES-128 encrypt/decrypt pipeline: takes one request per cycle, each with its own key and
// operation bit, and presents the result at the end of 22 register stages. An input register
// and 10 key expansion stages (one schedule step each) produce the last round key, the next
// stage applies the initial round key, and the last 10 stages each run one cipher round
// together with one forward or backward key schedule step. All stages advance together; when
// a finished result is not taken the whole pipe holds and no request is accepted.
`include "aes128_block_cipher_top_assert.svh"

module aes128_block_cipher_top (
	input  logic              clk,
	input  logic              arst_n,
	aes128_in_if.sink         in_ch,
	aes128_out_if.source      out_ch
);

	localparam int NKS = aes128_pkg::NUM_RND + 1;

	aes128_pkg::kstg_t kx_s [NKS];
	aes128_pkg::pipe_t rd_s [NKS];
	logic              en;
	logic [2*NKS-1:0]  vlds;

	assign en          = !rd_s[NKS-1].vld || out_ch.ready;
	assign in_ch.ready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_s[0] <= '0;
		end else if (en) begin
			kx_s[0].vld  <= in_ch.valid;
			kx_s[0].op   <= in_ch.operation;
			kx_s[0].key  <= {in_ch.key_hi, in_ch.key_lo};
			kx_s[0].data <= {in_ch.data_in_hi, in_ch.data_in_lo};
			kx_s[0].kx   <= {in_ch.key_hi, in_ch.key_lo};
		end
	end

	// key expansion stages, one schedule step each
	for (genvar i = 1; i < NKS; i++) begin : g_kexp
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				kx_s[i] <= '0;
			end else if (en) begin
				kx_s[i].vld  <= kx_s[i-1].vld;
				kx_s[i].op   <= kx_s[i-1].op;
				kx_s[i].key  <= kx_s[i-1].key;
				kx_s[i].data <= kx_s[i-1].data;
				kx_s[i].kx   <= aes128_pkg::key_fwd(kx_s[i-1].kx, aes128_pkg::rcon(4'(i)));
			end
		end
	end

	// initial round key: original key to encrypt, last round key to decrypt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s[0] <= '0;
		end else if (en) begin
			rd_s[0].vld <= kx_s[NKS-1].vld;
			rd_s[0].op  <= kx_s[NKS-1].op;
			rd_s[0].k   <= kx_s[NKS-1].op ? kx_s[NKS-1].kx : kx_s[NKS-1].key;
			rd_s[0].s   <= kx_s[NKS-1].data ^
				(kx_s[NKS-1].op ? kx_s[NKS-1].kx : kx_s[NKS-1].key);
		end
	end

	for (genvar j = 1; j < NKS; j++) begin : g_rnd
		aes128_round u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.rnd    (4'(j)),
			.d      (rd_s[j-1]),
			.q      (rd_s[j])
		);
	end

	assign out_ch.valid       = rd_s[NKS-1].vld;
	assign out_ch.data_out_hi = rd_s[NKS-1].s[127:64];
	assign out_ch.data_out_lo = rd_s[NKS-1].s[63:0];

	for (genvar v = 0; v < NKS; v++) begin : g_vld
		assign vlds[v]       = kx_s[v].vld;
		assign vlds[NKS + v] = rd_s[v].vld;
	end

	`AES128_ASSERT_NEXT(a_first_stage_load, en, kx_s[0].vld == $past(in_ch.valid))
	`AES128_ASSERT_NEXT(a_stall_holds_all, !en, $stable(vlds))
	`AES128_ASSERT_NEXT(a_last_stage_load, en && rd_s[NKS-2].vld, rd_s[NKS-1].vld)
	`AES128_ASSERT_NOW(a_ready_when_empty, !rd_s[NKS-1].vld, in_ch.ready)

endmodule

>>> test/aes128_block_cipher_top_tb.sv
// testbench for the aes-128 encrypt/decrypt pipeline with its own cipher predictor
`timescale 1ns / 1ps

module aes128_block_cipher_top_tb;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;
	localparam int PIPE_LATENCY = 22;

	typedef struct packed {
		logic         op;
		logic [127:0] key;
		logic [127:0] blk;
	} cipher_req_t;

	logic clk;
	logic arst_n;

	aes128_in_if  in_ch();
	aes128_out_if out_ch();

	aes128_block_cipher_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	cipher_req_t  pending_reqs[$];
	logic [127:0] expected_blocks[$];
	int           mismatch_count;
	bit           hold_sender;
	int           burst_left;
	int           gap_left;
	int           stall_phase;
	int           stall_period;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// gf(2^8) helpers
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 0; i < 254; i++) r = gf_mul(r, x);
		return r;
	endfunction

	logic [7:0] fwd_sub[256];
	logic [7:0] inv_sub[256];

	initial begin
		logic [7:0] b;
		for (int x = 0; x < 256; x++) begin
			b = gf_inv(x[7:0]);
			b = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
				^ 8'h63;
			fwd_sub[x] = b;
			inv_sub[b] = x[7:0];
		end
	end

	// byte n of a 128-bit word sits at bits 127-8n
	function automatic logic [127:0] cipher_block(input cipher_req_t r);
		logic [7:0] rk[176];
		logic [7:0] s[16];
		logic [7:0] o[16];
		logic [7:0] t[4];
		logic [7:0] a[4];
		logic [7:0] tmp, rc, v;
		logic [7:0] fwd_m[4];
		logic [7:0] inv_m[4];
		logic [127:0] res;
		int rnd;
		fwd_m = '{8'h02, 8'h03, 8'h01, 8'h01};
		inv_m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		rc = 8'h01;
		for (int n = 0; n < 16; n++) begin
			rk[n] = r.key[127-8*n -: 8];
			s[n] = r.blk[127-8*n -: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1)+j];
			if (i % 4 == 0) begin
				tmp = t[0];
				t[0] = fwd_sub[t[1]] ^ rc;
				t[1] = fwd_sub[t[2]];
				t[2] = fwd_sub[t[3]];
				t[3] = fwd_sub[tmp];
				rc = gf_mul(rc, 8'h02);
			end
			for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ t[j];
		end
		if (r.op == OP_ENCRYPT) begin
			for (int i = 0; i < 16; i++) s[i] ^= rk[i];
			for (rnd = 1; rnd <= 10; rnd++) begin
				for (int i = 0; i < 16; i++) o[i] = fwd_sub[s[i]];
				for (int rr = 0; rr < 4; rr++)
					for (int c = 0; c < 4; c++) s[rr+4*c] = o[rr+4*((c+rr)&3)];
				if (rnd != 10)
					for (int c = 0; c < 4; c++) begin
						for (int rr = 0; rr < 4; rr++) a[rr] = s[rr+4*c];
						for (int rr = 0; rr < 4; rr++) begin
							v = 8'h00;
							for (int k = 0; k < 4; k++) v ^= gf_mul(fwd_m[(k-rr+4)&3], a[k]);
							s[rr+4*c] = v;
						end
					end
				for (int i = 0; i < 16; i++) s[i] ^= rk[16*rnd+i];
			end
		end else begin
			for (int i = 0; i < 16; i++) s[i] ^= rk[160+i];
			for (rnd = 9; rnd >= 0; rnd--) begin
				o = s;
				for (int rr = 0; rr < 4; rr++)
					for (int c = 0; c < 4; c++) s[rr+4*((c+rr)&3)] = o[rr+4*c];
				for (int i = 0; i < 16; i++) s[i] = inv_sub[s[i]] ^ rk[16*rnd+i];
				if (rnd != 0)
					for (int c = 0; c < 4; c++) begin
						for (int rr = 0; rr < 4; rr++) a[rr] = s[rr+4*c];
						for (int rr = 0; rr < 4; rr++) begin
							v = 8'h00;
							for (int k = 0; k < 4; k++) v ^= gf_mul(inv_m[(k-rr+4)&3], a[k]);
							s[rr+4*c] = v;
						end
					end
			end
		end
		for (int n = 0; n < 16; n++) res[127-8*n -: 8] = s[n];
		return res;
	endfunction

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.operation <= 1'b0;
			in_ch.key_hi <= '0;
			in_ch.key_lo <= '0;
			in_ch.data_in_hi <= '0;
			in_ch.data_in_lo <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid) expected_blocks.push_back(
					cipher_block('{in_ch.operation, {in_ch.key_hi, in_ch.key_lo},
						{in_ch.data_in_hi, in_ch.data_in_lo}}));
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_sender) begin
					cipher_req_t nx;
					nx = pending_reqs.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.operation <= nx.op;
					{in_ch.key_hi, in_ch.key_lo} <= nx.key;
					{in_ch.data_in_hi, in_ch.data_in_lo} <= nx.blk;
					if (burst_left > 0) burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(0, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase <= 0;
			stall_period <= 7;
		end else begin
			if (stall_phase >= stall_period) begin
				stall_phase <= 0;
				stall_period <= $urandom_range(1, 30);
			end else stall_phase <= stall_phase + 1;
			out_ch.ready <= (stall_period > 20) || (stall_phase % 4 != 3 &&
				stall_phase < stall_period - 1);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_blocks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h %h", out_ch.data_out_hi, out_ch.data_out_lo);
			end else begin
				logic [127:0] exp_blk;
				exp_blk = expected_blocks.pop_front();
				if (out_ch.data_out_hi !== exp_blk[127:64]
					|| out_ch.data_out_lo !== exp_blk[63:0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %h %h got %h %h", exp_blk[127:64],
							exp_blk[63:0], out_ch.data_out_hi, out_ch.data_out_lo);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		cipher_req_t r;
		mismatch_count = 0;
		hold_sender = 1'b0;
		arst_n = 1'b0;
		// directed: fips-197 vector both ways, all-zero and all-one extremes
		pending_reqs.push_back('{OP_ENCRYPT, 128'h000102030405060708090a0b0c0d0e0f,
			128'h00112233445566778899aabbccddeeff});
		pending_reqs.push_back('{OP_DECRYPT, 128'h000102030405060708090a0b0c0d0e0f,
			128'h69c4e0d86a7b0430d8cdb78070b4c55a});
		pending_reqs.push_back('{OP_ENCRYPT, 128'h2b7e151628aed2a6abf7158809cf4f3c,
			128'h3243f6a8885a308d313198a2e0370734});
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back('{i[0], {128{i[1]}}, {128{i[2]}}});
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back('{i[0], 128'h1 << (i * 17), ~(128'h1 << (i * 19))});
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		// drain the pipe once before the random part
		hold_sender = 1'b1;
		@(posedge clk);
		wait (expected_blocks.size() == 0 && !in_ch.valid);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		hold_sender = 1'b0;
		for (int i = 0; i < 1280; i++) begin
			r.op = $urandom_range(0, 1);
			r.key = rand128();
			r.blk = rand128();
			// occasional round-trip pairs: decrypt what was just encrypted and vice versa
			pending_reqs.push_back(r);
			if ($urandom_range(0, 7) == 0) begin
				r.blk = cipher_block(r);
				r.op = ~r.op;
				pending_reqs.push_back(r);
				i++;
			end
		end
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		wait (expected_blocks.size() == 0 && !in_ch.valid);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && expected_blocks.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
